// File: hw/rtl/dfc_pkg.sv
// Shared types, constants and helpers of the datagram frame checker.
package dfc_pkg;

  localparam logic [31:0] TAG_RESET     = 32'h89AB_CDEF;
  localparam logic [7:0]  DATA_OP_RESET = 8'd100;
  localparam logic [7:0]  ACK_OP_RESET  = 8'd97;

  localparam int unsigned COUNT_W = 17;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Byte positions within a frame.
  localparam logic [COUNT_W-1:0] TAG_BYTES      = 17'd4;
  localparam logic [COUNT_W-1:0] SIZE_LAST      = 17'd5;
  localparam logic [COUNT_W-1:0] OPCODE_POS     = 17'd6;
  localparam logic [COUNT_W-1:0] HDR_FIRST      = 17'd7;
  localparam logic [COUNT_W-1:0] HDR_LAST       = 17'd30;
  // A payload byte leaves the trailer window once the count reaches this.
  localparam logic [COUNT_W-1:0] PAYLOAD_COUNT  = 17'd35;
  localparam logic [COUNT_W-1:0] DATA_MIN_LEN   = 17'd35;
  localparam logic [COUNT_W-1:0] ACK_MIN_LEN    = 17'd15;
  localparam logic [15:0]        DATA_OVERHEAD  = 16'd35;
  localparam int unsigned        HDR_WORDS      = 6;

  localparam int unsigned TDATA_W = 224;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NOT_TAGGED = 3'd1,
    ST_CHECKSUM   = 3'd2,
    ST_SIZE       = 3'd3,
    ST_OPCODE     = 3'd4,
    ST_SHORT      = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    REG_FRAME_TAG = 2'd0,
    REG_DATA_OP   = 2'd1,
    REG_ACK_OP    = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] frame_tag;
    logic [7:0]  data_opcode;
    logic [7:0]  ack_opcode;
  } cfg_t;

  typedef struct packed {
    status_t     status;
    logic        packet_kind;
    logic [31:0] source_ip;
    logic [31:0] gateway_ip;
    logic [31:0] process_id;
    logic [31:0] start_sec;
    logic [31:0] start_usec;
    logic [31:0] sequence_res;
    logic [15:0] payload_length;
  } verdict_t;

  // One queue entry holds everything one input byte caused.
  typedef struct packed {
    logic       has_pay;
    logic [7:0] pay_byte;
    logic       has_verd;
    verdict_t   verdict;
  } entry_t;

  function automatic logic [31:0] swap32(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

// File: hw/rtl/dfc_front.sv
// Front end: tracks frame state per byte and builds queue entries.
module dfc_front (
  input  logic            clk,
  input  logic            rst_n,
  input  dfc_pkg::cfg_t   cfg_i,
  input  logic            accept_i,
  input  logic [7:0]      byte_i,
  input  logic            last_i,
  output logic            push_o,
  output dfc_pkg::entry_t entry_o
);

  logic [dfc_pkg::COUNT_W-1:0] byte_count_r, byte_count_nxt;
  logic [31:0] running_sum_r, running_sum_nxt;
  logic [31:0] trailer_r, trailer_nxt;
  logic [31:0] tag_r, tag_nxt;
  logic [15:0] size_r, size_nxt;
  logic [7:0]  opcode_r, opcode_nxt;
  logic [31:0] hdr_r   [dfc_pkg::HDR_WORDS];
  logic [31:0] hdr_nxt [dfc_pkg::HDR_WORDS];

  logic [4:0] hdr_off;
  logic [2:0] hdr_sel;
  logic       in_hdr;
  logic       has_pay;
  dfc_pkg::status_t status;
  dfc_pkg::verdict_t verdict;

  assign hdr_off = byte_count_r[4:0] - dfc_pkg::HDR_FIRST[4:0];
  assign hdr_sel = hdr_off[4:2];
  assign in_hdr  = (byte_count_r >= dfc_pkg::HDR_FIRST) && (byte_count_r <= dfc_pkg::HDR_LAST);
  assign has_pay = (byte_count_r >= dfc_pkg::PAYLOAD_COUNT) &&
                   (opcode_r == cfg_i.data_opcode);

  always_comb begin
    running_sum_nxt = running_sum_r;
    if (byte_count_r >= dfc_pkg::TAG_BYTES) begin
      running_sum_nxt = running_sum_r + {24'd0, trailer_r[31:24]};
    end
    trailer_nxt = {trailer_r[23:0], byte_i};

    tag_nxt = tag_r;
    if (byte_count_r < dfc_pkg::TAG_BYTES) begin
      unique case (byte_count_r[1:0])
        2'd0: tag_nxt[7:0]   = byte_i;
        2'd1: tag_nxt[15:8]  = byte_i;
        2'd2: tag_nxt[23:16] = byte_i;
        2'd3: tag_nxt[31:24] = byte_i;
        default: tag_nxt = tag_r;
      endcase
    end

    size_nxt = size_r;
    if (byte_count_r >= dfc_pkg::TAG_BYTES && byte_count_r <= dfc_pkg::SIZE_LAST) begin
      size_nxt = {size_r[7:0], byte_i};
    end

    opcode_nxt = (byte_count_r == dfc_pkg::OPCODE_POS) ? byte_i : opcode_r;

    for (int i = 0; i < dfc_pkg::HDR_WORDS; i++) begin
      hdr_nxt[i] = hdr_r[i];
      if (in_hdr && hdr_sel == 3'(i)) begin
        hdr_nxt[i] = {hdr_r[i][23:0], byte_i};
      end
    end

    byte_count_nxt = (byte_count_r < dfc_pkg::COUNT_MAX) ? byte_count_r + 1'b1
                                                        : byte_count_r;
  end

  // Verdict of a frame whose final byte is the current one.
  always_comb begin
    priority if (byte_count_nxt < dfc_pkg::TAG_BYTES) begin
      status = dfc_pkg::ST_SHORT;
    end else if (tag_nxt != cfg_i.frame_tag) begin
      status = dfc_pkg::ST_NOT_TAGGED;
    end else if (running_sum_nxt != trailer_nxt) begin
      status = dfc_pkg::ST_CHECKSUM;
    end else if ({1'b0, size_nxt} != byte_count_nxt) begin
      status = dfc_pkg::ST_SIZE;
    end else if (opcode_nxt == cfg_i.data_opcode) begin
      status = (byte_count_nxt < dfc_pkg::DATA_MIN_LEN) ? dfc_pkg::ST_SHORT : dfc_pkg::ST_OK;
    end else if (opcode_nxt == cfg_i.ack_opcode) begin
      status = (byte_count_nxt < dfc_pkg::ACK_MIN_LEN) ? dfc_pkg::ST_SHORT : dfc_pkg::ST_OK;
    end else begin
      status = dfc_pkg::ST_OPCODE;
    end

    verdict = '0;
    verdict.status = status;
    if (status == dfc_pkg::ST_OK) begin
      if (opcode_nxt == cfg_i.data_opcode) begin
        verdict.source_ip      = dfc_pkg::swap32(hdr_nxt[0]);
        verdict.gateway_ip     = dfc_pkg::swap32(hdr_nxt[1]);
        verdict.process_id     = hdr_nxt[2];
        verdict.start_sec      = hdr_nxt[3];
        verdict.start_usec     = hdr_nxt[4];
        verdict.sequence_res   = hdr_nxt[5];
        verdict.payload_length = size_nxt - dfc_pkg::DATA_OVERHEAD;
      end else begin
        verdict.packet_kind  = 1'b1;
        verdict.sequence_res = hdr_nxt[0];
      end
    end
  end

  assign push_o = accept_i && (has_pay || last_i);

  always_comb begin
    entry_o          = '0;
    entry_o.has_pay  = has_pay;
    entry_o.pay_byte = trailer_r[31:24];
    entry_o.has_verd = last_i;
    entry_o.verdict  = verdict;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r  <= '0;
      running_sum_r <= '0;
      trailer_r     <= '0;
      tag_r         <= '0;
      size_r        <= '0;
      opcode_r      <= '0;
    end else if (accept_i) begin
      if (last_i) begin
        byte_count_r  <= '0;
        running_sum_r <= '0;
        trailer_r     <= '0;
        tag_r         <= '0;
        size_r        <= '0;
        opcode_r      <= '0;
      end else begin
        byte_count_r  <= byte_count_nxt;
        running_sum_r <= running_sum_nxt;
        trailer_r     <= trailer_nxt;
        tag_r         <= tag_nxt;
        size_r        <= size_nxt;
        opcode_r      <= opcode_nxt;
      end
    end
  end

  // Header words are fully rewritten by any frame that reaches them.
  always_ff @(posedge clk) begin
    if (accept_i) begin
      for (int i = 0; i < dfc_pkg::HDR_WORDS; i++) begin
        hdr_r[i] <= hdr_nxt[i];
      end
    end
  end

  a_verdict_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (push_o && entry_o.has_verd) |-> (accept_i && last_i))
    else $error("verdict queued without a final byte");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (accept_i && last_i) |=> (byte_count_r == '0 && running_sum_r == '0))
    else $error("frame state not cleared after final byte");

  a_payload_position: assert property (@(posedge clk) disable iff (!rst_n)
    (push_o && entry_o.has_pay) |-> (byte_count_r >= dfc_pkg::PAYLOAD_COUNT))
    else $error("payload byte queued from header or trailer position");

endmodule

// File: hw/rtl/dfc_back.sv
// Back end: entry queue and the output register that issues result items.
module dfc_back #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push_i,
  input  dfc_pkg::entry_t               entry_i,
  output logic                          push_ready_o,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [dfc_pkg::TDATA_W-1:0]   out_tdata,
  output logic                          out_tlast
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR   = PTR_W'(DEPTH - 1);

  dfc_pkg::entry_t mem_r [DEPTH];

  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             pay_sent_r, pay_sent_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [dfc_pkg::TDATA_W-1:0] out_data_r, out_data_nxt;
  logic             out_last_r, out_last_nxt;
  logic             empty, load, pop;
  dfc_pkg::entry_t  head;
  dfc_pkg::verdict_t hv;

  assign empty        = (count_r == '0);
  assign push_ready_o = (count_r != FULL_COUNT);
  assign head         = mem_r[rd_ptr_r];
  assign hv           = head.verdict;
  assign load         = !out_valid_r || out_tready;

  // A head entry with both a payload byte and a verdict is issued in two steps.
  always_comb begin
    pop           = 1'b0;
    pay_sent_nxt  = pay_sent_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    if (load) begin
      out_valid_nxt = !empty;
      if (!empty) begin
        if (head.has_pay && !pay_sent_r) begin
          out_data_nxt = {{(dfc_pkg::TDATA_W-8){1'b0}}, head.pay_byte};
          out_last_nxt = 1'b0;
          if (head.has_verd) begin
            pay_sent_nxt = 1'b1;
          end else begin
            pop = 1'b1;
          end
        end else begin
          out_data_nxt = {4'd0, hv.payload_length, hv.sequence_res, hv.start_usec,
                          hv.start_sec, hv.process_id, hv.gateway_ip, hv.source_ip,
                          hv.packet_kind, hv.status, 8'd0};
          out_last_nxt = 1'b1;
          pop          = 1'b1;
          pay_sent_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      count_r     <= '0;
      pay_sent_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (push_i) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r     <= count_r + CNT_W'(push_i) - CNT_W'(pop);
      pay_sent_r  <= pay_sent_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= entry_i;
    end
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_COUNT)
    else $error("queue count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("pop from empty queue");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push_i && count_r == FULL_COUNT))
    else $error("push into full queue");

  a_split_entry: assert property (@(posedge clk) disable iff (!rst_n)
    pay_sent_r |-> (!empty && head.has_verd))
    else $error("payload-sent flag set without a pending verdict");

endmodule

// File: hw/rtl/datagram_frame_checker_top.sv
// Datagram frame checker: top level with configuration registers.
// Each accepted byte is classified in the same cycle; its results enter the queue
// and then the output register, once earlier entries have left and the output is free.
// Throughput is one byte per cycle while the queue is not full; a final byte that
// also releases a payload byte yields two output items, absorbed by the QUEUE_DEPTH-entry queue.
// Reset (rst_n low, synchronous) clears frame state, queue and output; registers
// return to tag 0x89ABCDEF, data opcode 100 and ack opcode 97.
module datagram_frame_checker_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // [7:0] data_byte
  input  logic                        in_tlast,   // final_byte
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [7:0] payload_byte, [10:8] status, [11] packet_kind, [43:12] source_ip,
  // [75:44] gateway_ip, [107:76] process_id, [139:108] start_sec,
  // [171:140] start_usec, [203:172] sequence_res, [219:204] payload_length
  output logic [dfc_pkg::TDATA_W-1:0] out_tdata,
  output logic                        out_tlast,  // is_verdict
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [3:0]                  cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);

  dfc_pkg::cfg_t   cfg_r;
  dfc_pkg::entry_t entry;
  logic            push;
  logic            push_ready;
  logic            accept;
  logic            cfg_write;

  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_tag   <= dfc_pkg::TAG_RESET;
      cfg_r.data_opcode <= dfc_pkg::DATA_OP_RESET;
      cfg_r.ack_opcode  <= dfc_pkg::ACK_OP_RESET;
    end else if (cfg_write) begin
      case (cfg_paddr[3:2])
        dfc_pkg::REG_FRAME_TAG: cfg_r.frame_tag   <= cfg_pwdata;
        dfc_pkg::REG_DATA_OP:   cfg_r.data_opcode <= cfg_pwdata[7:0];
        dfc_pkg::REG_ACK_OP:    cfg_r.ack_opcode  <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      dfc_pkg::REG_FRAME_TAG: cfg_prdata = cfg_r.frame_tag;
      dfc_pkg::REG_DATA_OP:   cfg_prdata = {24'd0, cfg_r.data_opcode};
      dfc_pkg::REG_ACK_OP:    cfg_prdata = {24'd0, cfg_r.ack_opcode};
      default:                cfg_prdata = 32'd0;
    endcase
  end

  assign in_tready = push_ready;
  assign accept    = in_tvalid && in_tready;

  dfc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_i    (cfg_r),
    .accept_i (accept),
    .byte_i   (in_tdata),
    .last_i   (in_tlast),
    .push_o   (push),
    .entry_o  (entry)
  );

  dfc_back #(
    .DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .push_i       (push),
    .entry_i      (entry),
    .push_ready_o (push_ready),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast)
  );

endmodule

// File: bench/frame_verdict_checker.sv
// Monitors the datagram frame checker's ports, predicts every result and compares it.
`timescale 1ns / 100ps
module frame_verdict_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  input  logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // [7:0] data_byte
  input  logic                        in_tlast,   // final_byte
  input  logic                        out_tvalid,
  input  logic                        out_tready,
  // [7:0] payload_byte, [10:8] status, [11] packet_kind, [43:12] source_ip,
  // [75:44] gateway_ip, [107:76] process_id, [139:108] start_sec,
  // [171:140] start_usec, [203:172] sequence_res, [219:204] payload_length
  input  logic [dfc_pkg::TDATA_W-1:0] out_tdata,
  input  logic                        out_tlast,  // is_verdict
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [3:0]                  cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  input  logic [31:0]                 cfg_prdata,
  input  logic                        cfg_pready,
  output int                          mismatches,
  output int                          results_owed
);

  typedef struct packed {
    logic             verdict;
    logic [7:0]       pay;
    dfc_pkg::status_t status;
    logic             kind;
    logic [31:0]      src_ip;
    logic [31:0]      gw_ip;
    logic [31:0]      pid;
    logic [31:0]      sec;
    logic [31:0]      usec;
    logic [31:0]      seq;
    logic [15:0]      plen;
  } frame_result_t;

  // Register copies, tracked from the writes seen on the configuration port.
  logic [31:0] tag_reg;
  logic [7:0]  dop_reg;
  logic [7:0]  aop_reg;

  // Per-frame state of the prediction.
  logic [16:0] byte_idx;
  logic [31:0] byte_sum;
  logic [31:0] tail_word;
  logic [31:0] tag_word;
  logic [15:0] size_word;
  logic [7:0]  op_byte;
  logic [31:0] hdr_word [dfc_pkg::HDR_WORDS];

  frame_result_t results_due[$];

  function automatic logic [31:0] byte_rev(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] seen,
                             input logic [31:0] want);
    if (seen !== want)
      flag_mismatch($sformatf("%s got %0h, expected %0h", name, seen, want));
  endtask

  task automatic clear_frame();
    byte_idx  = '0;
    byte_sum  = '0;
    tail_word = '0;
    tag_word  = '0;
    size_word = '0;
    op_byte   = '0;
  endtask

  task automatic absorb_byte(input logic [7:0] b, input logic fin);
    logic [16:0]      c;
    logic [7:0]       leaving;
    frame_result_t    r;
    dfc_pkg::status_t st;
    int               w;
    c = byte_idx;
    // Once four bytes are held, the oldest one is known not to be trailer.
    if (c >= dfc_pkg::TAG_BYTES) begin
      leaving  = tail_word[31:24];
      byte_sum = byte_sum + leaving;
      if (c >= dfc_pkg::PAYLOAD_COUNT && op_byte == dop_reg) begin
        r = '0;
        r.pay = leaving;
        results_due.push_back(r);
      end
    end
    tail_word = {tail_word[23:0], b};
    if (c < dfc_pkg::TAG_BYTES) tag_word[8*c[1:0] +: 8] = b;
    else if (c <= dfc_pkg::SIZE_LAST) size_word = {size_word[7:0], b};
    else if (c == dfc_pkg::OPCODE_POS) op_byte = b;
    else if (c <= dfc_pkg::HDR_LAST) begin
      w = int'(c - dfc_pkg::HDR_FIRST) >> 2;
      hdr_word[w] = {hdr_word[w][23:0], b};
    end
    if (c != dfc_pkg::COUNT_MAX) c = c + 1'b1;
    byte_idx = c;
    if (fin) begin
      r = '0;
      r.verdict = 1'b1;
      if (c < dfc_pkg::TAG_BYTES) st = dfc_pkg::ST_SHORT;
      else if (tag_word != tag_reg) st = dfc_pkg::ST_NOT_TAGGED;
      else if (byte_sum != tail_word) st = dfc_pkg::ST_CHECKSUM;
      else if ({1'b0, size_word} != c) st = dfc_pkg::ST_SIZE;
      else if (op_byte == dop_reg)
        st = (c < dfc_pkg::DATA_MIN_LEN) ? dfc_pkg::ST_SHORT : dfc_pkg::ST_OK;
      else if (op_byte == aop_reg)
        st = (c < dfc_pkg::ACK_MIN_LEN) ? dfc_pkg::ST_SHORT : dfc_pkg::ST_OK;
      else st = dfc_pkg::ST_OPCODE;
      r.status = st;
      if (st == dfc_pkg::ST_OK) begin
        if (op_byte == dop_reg) begin
          r.src_ip = byte_rev(hdr_word[0]);
          r.gw_ip  = byte_rev(hdr_word[1]);
          r.pid    = hdr_word[2];
          r.sec    = hdr_word[3];
          r.usec   = hdr_word[4];
          r.seq    = hdr_word[5];
          r.plen   = size_word - dfc_pkg::DATA_OVERHEAD;
        end else begin
          r.kind = 1'b1;
          r.seq  = hdr_word[0];
        end
      end
      results_due.push_back(r);
      clear_frame();
    end
  endtask

  always @(posedge clk) begin : watch
    frame_result_t want;
    logic [31:0]   reg_want;
    if (!rst_n) begin
      tag_reg = dfc_pkg::TAG_RESET;
      dop_reg = dfc_pkg::DATA_OP_RESET;
      aop_reg = dfc_pkg::ACK_OP_RESET;
      clear_frame();
      for (int i = 0; i < dfc_pkg::HDR_WORDS; i++) hdr_word[i] = '0;
      results_due.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready) begin
        if (cfg_pwrite) begin
          case (cfg_paddr[3:2])
            dfc_pkg::REG_FRAME_TAG: tag_reg = cfg_pwdata;
            dfc_pkg::REG_DATA_OP:   dop_reg = cfg_pwdata[7:0];
            dfc_pkg::REG_ACK_OP:    aop_reg = cfg_pwdata[7:0];
            default: ;
          endcase
        end else begin
          case (cfg_paddr[3:2])
            dfc_pkg::REG_FRAME_TAG: reg_want = tag_reg;
            dfc_pkg::REG_DATA_OP:   reg_want = {24'd0, dop_reg};
            dfc_pkg::REG_ACK_OP:    reg_want = {24'd0, aop_reg};
            default:                reg_want = cfg_prdata;
          endcase
          check_field($sformatf("register read at %0h", cfg_paddr), cfg_prdata, reg_want);
        end
      end
      // Results leave only after the edge that accepts their byte, so check them first.
      if (out_tvalid && out_tready) begin
        if (results_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected item, tlast %b tdata %h",
                                  out_tlast, out_tdata));
        end else begin
          want = results_due.pop_front();
          check_field("is_verdict", 32'(out_tlast), 32'(want.verdict));
          check_field("payload_byte", 32'(out_tdata[7:0]), 32'(want.pay));
          check_field("status", 32'(out_tdata[10:8]), 32'(want.status));
          check_field("packet_kind", 32'(out_tdata[11]), 32'(want.kind));
          check_field("source_ip", out_tdata[43:12], want.src_ip);
          check_field("gateway_ip", out_tdata[75:44], want.gw_ip);
          check_field("process_id", out_tdata[107:76], want.pid);
          check_field("start_sec", out_tdata[139:108], want.sec);
          check_field("start_usec", out_tdata[171:140], want.usec);
          check_field("sequence_res", out_tdata[203:172], want.seq);
          check_field("payload_length", 32'(out_tdata[219:204]), 32'(want.plen));
        end
      end
      if (in_tvalid && in_tready) absorb_byte(in_tdata, in_tlast);
    end
    results_owed = results_due.size();
  end

endmodule

// File: bench/tb_datagram_frame_checker_top.sv
// Testbench top: clock, reset, frame stimulus, register settings and the final verdict.
`timescale 1ns / 100ps
module tb_datagram_frame_checker_top;

  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_BYTES = 1010;

  typedef enum int {
    FLAW_NONE  = 0,
    FLAW_TAG   = 1,
    FLAW_SUM   = 2,
    FLAW_SIZE  = 3,
    FLAW_NOISE = 4
  } flaw_t;

  logic                        clk;
  logic                        rst_n;
  logic                        in_tvalid;
  logic                        in_tready;
  logic [7:0]                  in_tdata;   // [7:0] data_byte
  logic                        in_tlast;   // final_byte
  logic                        out_tvalid;
  logic                        out_tready = 1'b0;
  // [7:0] payload_byte, [10:8] status, [11] packet_kind, [43:12] source_ip,
  // [75:44] gateway_ip, [107:76] process_id, [139:108] start_sec,
  // [171:140] start_usec, [203:172] sequence_res, [219:204] payload_length
  logic [dfc_pkg::TDATA_W-1:0] out_tdata;
  logic                        out_tlast;  // is_verdict
  logic                        cfg_psel;
  logic                        cfg_penable;
  logic                        cfg_pwrite;
  logic [3:0]                  cfg_paddr;
  logic [31:0]                 cfg_pwdata;
  logic [31:0]                 cfg_prdata;
  logic                        cfg_pready;

  int mismatches;
  int results_owed;

  logic [31:0] cur_tag;
  logic [7:0]  cur_dop;
  logic [7:0]  cur_aop;
  int          burst_left;
  int          random_bytes;
  int          idle_cycles;
  int          rx_mode;
  int          rx_left;
  int          rx_hold;
  logic        rx_open = 1'b0;

  datagram_frame_checker_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  frame_verdict_checker verdict_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tlast     (in_tlast),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_prdata   (cfg_prdata),
    .cfg_pready   (cfg_pready),
    .mismatches   (mismatches),
    .results_owed (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The receiver switches between always ready, random stalls and long stall runs.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(40, 400);
    end
    rx_left--;
    case (rx_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      default: begin
        if (rx_hold == 0) begin
          rx_open = !rx_open;
          rx_hold = rx_open ? $urandom_range(1, 12) : $urandom_range(1, 20);
        end
        rx_hold--;
        out_tready <= rx_open;
      end
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("** datagram_frame_checker_top: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic push_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(200, 600)
                                               : $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic send_frame(input int len, input logic [7:0] opc, input flaw_t flaw,
                            input int fill);
    logic [7:0]  fb[$];
    logic [31:0] tag;
    logic [31:0] sum;
    logic [15:0] size;
    for (int i = 0; i < len; i++) fb.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
    if (flaw != FLAW_NOISE) begin
      tag = cur_tag;
      if (flaw == FLAW_TAG) tag = tag ^ (32'd1 << $urandom_range(0, 31));
      size = 16'(len);
      if (flaw == FLAW_SIZE) size = size ^ (16'd1 << $urandom_range(0, 15));
      for (int i = 0; i < 4 && i < len; i++) fb[i] = tag[8*i +: 8];
      if (len > 4) fb[4] = size[15:8];
      if (len > 5) fb[5] = size[7:0];
      if (len > 6) fb[6] = opc;
      // The trailer is written last; in very short frames it overlays the header.
      if (len >= 4) begin
        sum = '0;
        for (int i = 0; i < len - 4; i++) sum = sum + fb[i];
        if (flaw == FLAW_SUM) sum = sum ^ (32'd1 << $urandom_range(0, 31));
        for (int i = 0; i < 4; i++) fb[len-4+i] = sum[31-8*i -: 8];
      end
    end
    for (int i = 0; i < len; i++) push_byte(fb[i], i == len - 1);
  endtask

  function automatic logic [7:0] stray_opcode();
    logic [7:0] op;
    do op = 8'($urandom); while (op == cur_dop || op == cur_aop);
    return op;
  endfunction

  task automatic random_frame();
    int pick;
    int len;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(35, 300) : $urandom_range(35, 70);
      send_frame(len, cur_dop, FLAW_NONE, -1);
    end else if (pick < 68) begin
      len = $urandom_range(15, 40);
      send_frame(len, cur_aop, FLAW_NONE, -1);
    end else if (pick < 80) begin
      len = $urandom_range(15, 60);
      send_frame(len, $urandom_range(0, 1) ? cur_dop : cur_aop,
                 flaw_t'($urandom_range(FLAW_TAG, FLAW_SIZE)), -1);
    end else if (pick < 88) begin
      len = $urandom_range(7, 50);
      send_frame(len, stray_opcode(), FLAW_NONE, -1);
    end else if (pick < 95) begin
      len = $urandom_range(1, 34);
      send_frame(len, $urandom_range(0, 1) ? cur_dop : cur_aop, FLAW_NONE, -1);
    end else begin
      len = $urandom_range(1, 60);
      send_frame(len, 8'($urandom), FLAW_NOISE, -1);
    end
    random_bytes += len;
  endtask

  // Waits until every expected result has come out and the block has settled.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Writes one register, then reads it back.
  task automatic set_reg(input dfc_pkg::reg_idx_t idx, input logic [31:0] value);
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    cfg_pwrite  <= 1'b1;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    @(negedge clk) cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk) cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      dfc_pkg::REG_FRAME_TAG: cur_tag = value;
      dfc_pkg::REG_DATA_OP:   cur_dop = value[7:0];
      dfc_pkg::REG_ACK_OP:    cur_aop = value[7:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [31:0] tag, input logic [7:0] dop,
                                input logic [7:0] aop);
    set_reg(dfc_pkg::REG_FRAME_TAG, tag);
    set_reg(dfc_pkg::REG_DATA_OP, {16'd0, 8'($urandom_range(0, 255)), dop});
    set_reg(dfc_pkg::REG_ACK_OP, {16'd0, 8'($urandom_range(0, 255)), aop});
  endtask

  initial begin : stimulus
    logic [7:0] op;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    cur_tag     = dfc_pkg::TAG_RESET;
    cur_dop     = dfc_pkg::DATA_OP_RESET;
    cur_aop     = dfc_pkg::ACK_OP_RESET;
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    @(negedge clk);

    // Directed frames under the reset settings.
    send_frame(1, cur_dop, FLAW_NONE, -1);
    send_frame(2, cur_dop, FLAW_NONE, 255);
    send_frame(3, cur_dop, FLAW_NONE, 0);
    send_frame(4, cur_dop, FLAW_NONE, -1);
    send_frame(35, cur_dop, FLAW_NONE, 0);
    send_frame(36, cur_dop, FLAW_NONE, 255);
    send_frame(15, cur_aop, FLAW_NONE, -1);
    send_frame(14, cur_aop, FLAW_NONE, -1);
    send_frame(34, cur_dop, FLAW_NONE, -1);
    send_frame(40, cur_dop, FLAW_TAG, -1);
    send_frame(40, cur_dop, FLAW_SUM, -1);
    send_frame(40, cur_dop, FLAW_SIZE, -1);
    send_frame(20, stray_opcode(), FLAW_NONE, -1);
    send_frame(60, cur_dop, FLAW_NONE, -1);
    send_frame(30, cur_aop, FLAW_NONE, -1);
    send_frame(25, cur_dop, FLAW_NOISE, -1);

    for (int phase = 1; phase <= 5; phase++) begin
      drain();
      case (phase)
        1: apply_settings(32'h0000_0000, 8'h00, 8'hFF);
        2: apply_settings(32'hFFFF_FFFF, 8'hFF, 8'h00);
        3: begin
          op = 8'($urandom);
          apply_settings($urandom, op, op ^ 8'($urandom_range(1, 255)));
        end
        // Equal opcodes: every such frame is treated as data.
        4: begin
          op = 8'($urandom);
          apply_settings($urandom, op, op);
        end
        default: apply_settings(dfc_pkg::TAG_RESET, dfc_pkg::DATA_OP_RESET,
                                dfc_pkg::ACK_OP_RESET);
      endcase
      while (random_bytes < RANDOM_BYTES * phase / 5) random_frame();
    end

    send_frame(40, cur_dop, FLAW_NONE, -1);
    drain();
    repeat (12) @(posedge clk);
    if (mismatches == 0) begin
      $display("** datagram_frame_checker_top: PASSED **");
    end else begin
      $display("** datagram_frame_checker_top: FAILED **");
    end
    $finish;
  end

endmodule
